>>> hdl/ssh_pkg.sv
package ssh_pkg;

    localparam int WORD_W     = 32;
    localparam int BLK_WORDS  = 16;
    localparam int ROUNDS     = 64;
    localparam int DIGEST_LEN = 8;

    typedef logic [WORD_W-1:0] t_word;

    localparam t_word IV [DIGEST_LEN] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam t_word ROUND_K [ROUNDS] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic t_word rotr(input t_word x, input int n);
        rotr = (x >> n) | (x << (WORD_W - n));
    endfunction

endpackage

>>> hdl/ssh_ram.sv
module ssh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

>>> hdl/sha256_stream_hasher_top.sv
// SHA-256 over a byte stream. Bytes enter one per beat and are packed into
// big-endian words in a 16-word block memory; a beat with last_byte set
// closes the message, and eight digest word beats follow, word 0 first.
// Input is stalled while a block is compressed, padded or read out. A
// byte that does not fill a block is taken without a stall; the 64th byte
// of a block starts a load, 64 rounds at one round per cycle and one
// chaining add. Closing a message writes the padding one word per cycle up
// to the end of the block, compresses once or twice, and with double_hash
// set writes the eight digest words back and compresses one more block
// before output.
module sha256_stream_hasher_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_byte_valid,
    input  logic        i_last_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_last_word
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PAD  = 3'd1;
    localparam logic [2:0] S_LOAD = 3'd2;
    localparam logic [2:0] S_COMP = 3'd3;
    localparam logic [2:0] S_ADD  = 3'd4;
    localparam logic [2:0] S_DH   = 3'd5;
    localparam logic [2:0] S_OUT  = 3'd6;

    typedef ssh_pkg::t_word t_word;

    logic [2:0]  r_state, n_state;
    logic        r_dh_cfg;
    logic [63:0] r_bits, n_bits;
    logic [23:0] r_acc, n_acc;
    logic        r_lastp, n_lastp;
    logic        r_fin, n_fin;
    logic        r_first, n_first;
    logic        r_lenok, n_lenok;
    logic        r_second, n_second;
    logic [3:0]  r_p, n_p;
    logic [5:0]  r_round, n_round;
    logic [2:0]  r_cnt, n_cnt;
    t_word       r_h [8];
    t_word       n_h [8];
    t_word       r_v [8];
    t_word       n_v [8];
    t_word       r_w [16];
    t_word       n_w [16];

    logic        we;
    logic [3:0]  waddr, raddr;
    t_word       wdata, rdata;

    ssh_ram #(.WIDTH(ssh_pkg::WORD_W), .DEPTH(ssh_pkg::BLK_WORDS)) u_blk (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    assign o_cfg_ready   = 1'b1;
    assign o_stall       = (r_state != S_IDLE);
    assign o_valid       = (r_state == S_OUT);
    assign o_digest_word = r_h[r_cnt];
    assign o_word_index  = r_cnt;
    assign o_last_word   = (r_cnt == 3'd7);

    logic  in_acc;
    t_word w_new, t1, t2, s0, s1, padword;
    logic [5:0] fill;

    assign in_acc = i_valid && !o_stall;
    assign fill   = r_bits[8:3];

    always_comb begin
        s1 = ssh_pkg::rotr(r_w[14], 17) ^ ssh_pkg::rotr(r_w[14], 19) ^ (r_w[14] >> 10);
        s0 = ssh_pkg::rotr(r_w[1], 7) ^ ssh_pkg::rotr(r_w[1], 18) ^ (r_w[1] >> 3);
        w_new = (r_round < 6'd16) ? rdata : (s1 + r_w[9] + s0 + r_w[0]);
        t1 = r_v[7] + (ssh_pkg::rotr(r_v[4], 6) ^ ssh_pkg::rotr(r_v[4], 11)
             ^ ssh_pkg::rotr(r_v[4], 25)) + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]))
             + ssh_pkg::ROUND_K[r_round] + w_new;
        t2 = (ssh_pkg::rotr(r_v[0], 2) ^ ssh_pkg::rotr(r_v[0], 13)
             ^ ssh_pkg::rotr(r_v[0], 22))
             + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));
        case (fill[1:0])
            2'd0:    padword = 32'h80000000;
            2'd1:    padword = {r_acc[7:0], 8'h80, 16'h0};
            2'd2:    padword = {r_acc[15:0], 8'h80, 8'h0};
            default: padword = {r_acc[23:0], 8'h80};
        endcase
    end

    always_comb begin
        n_state  = r_state;
        n_bits   = r_bits;
        n_acc    = r_acc;
        n_lastp  = r_lastp;
        n_fin    = r_fin;
        n_first  = r_first;
        n_lenok  = r_lenok;
        n_second = r_second;
        n_p      = r_p;
        n_round  = r_round;
        n_cnt    = r_cnt;
        n_h      = r_h;
        n_v      = r_v;
        n_w      = r_w;
        we       = 1'b0;
        waddr    = r_p;
        wdata    = 32'h0;
        raddr    = 4'd0;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_lastp = i_last_byte;
                    if (i_byte_valid) begin
                        n_acc  = {r_acc[15:0], i_data_byte};
                        n_bits = r_bits + 64'd8;
                        if (fill[1:0] == 2'd3) begin
                            we    = 1'b1;
                            waddr = fill[5:2];
                            wdata = {r_acc, i_data_byte};
                        end
                    end
                    if (i_byte_valid && fill == 6'd63) begin
                        n_state = S_LOAD;
                    end else if (i_last_byte) begin
                        n_state = S_PAD;
                        n_fin   = 1'b1;
                        n_first = 1'b1;
                        n_p     = n_bits[8:5];
                        n_lenok = (n_bits[8:6] != 3'd7);
                    end
                end
            end
            S_PAD: begin
                we      = 1'b1;
                waddr   = r_p;
                n_first = 1'b0;
                if (r_first) begin
                    wdata = padword;
                end else if (r_lenok && r_p == 4'd14) begin
                    wdata = r_bits[63:32];
                end else if (r_lenok && r_p == 4'd15) begin
                    wdata = r_bits[31:0];
                end
                // The length may land in the first word written only when it is word 14 or 15.
                if (r_first && r_lenok && r_p >= 4'd14) begin
                    wdata = (r_p == 4'd14) ? r_bits[63:32] : r_bits[31:0];
                end
                n_p = r_p + 4'd1;
                if (r_p == 4'd15) begin
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                raddr   = 4'd0;
                n_v     = r_h;
                n_round = 6'd0;
                n_state = S_COMP;
            end
            S_COMP: begin
                raddr = r_round[3:0] + 4'd1;
                for (int i = 0; i < 15; i++) begin
                    n_w[i] = r_w[i+1];
                end
                n_w[15] = w_new;
                n_v[7] = r_v[6];
                n_v[6] = r_v[5];
                n_v[5] = r_v[4];
                n_v[4] = r_v[3] + t1;
                n_v[3] = r_v[2];
                n_v[2] = r_v[1];
                n_v[1] = r_v[0];
                n_v[0] = t1 + t2;
                n_round = r_round + 6'd1;
                if (r_round == 6'd63) begin
                    n_state = S_ADD;
                end
            end
            S_ADD: begin
                for (int i = 0; i < 8; i++) begin
                    n_h[i] = r_h[i] + r_v[i];
                end
                n_cnt = 3'd0;
                if (r_fin) begin
                    if (!r_lenok) begin
                        n_lenok = 1'b1;
                        n_first = 1'b0;
                        n_p     = 4'd0;
                        n_state = S_PAD;
                    end else if (r_dh_cfg && !r_second) begin
                        n_state = S_DH;
                    end else begin
                        n_state = S_OUT;
                    end
                end else if (r_lastp) begin
                    n_fin   = 1'b1;
                    n_first = 1'b1;
                    n_p     = 4'd0;
                    n_lenok = 1'b1;
                    n_state = S_PAD;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_DH: begin
                // The first digest becomes a fresh 32-byte message.
                we    = 1'b1;
                waddr = {1'b0, r_cnt};
                wdata = r_h[r_cnt];
                n_cnt = r_cnt + 3'd1;
                if (r_cnt == 3'd7) begin
                    n_h      = ssh_pkg::IV;
                    n_bits   = 64'd256;
                    n_acc    = 24'h0;
                    n_second = 1'b1;
                    n_first  = 1'b1;
                    n_lenok  = 1'b1;
                    n_p      = 4'd8;
                    n_state  = S_PAD;
                end
            end
            S_OUT: begin
                if (!i_stall) begin
                    n_cnt = r_cnt + 3'd1;
                    if (r_cnt == 3'd7) begin
                        n_h      = ssh_pkg::IV;
                        n_bits   = 64'd0;
                        n_fin    = 1'b0;
                        n_second = 1'b0;
                        n_lastp  = 1'b0;
                        n_state  = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_dh_cfg <= 1'b0;
            r_bits   <= 64'd0;
            r_lastp  <= 1'b0;
            r_fin    <= 1'b0;
            r_first  <= 1'b0;
            r_lenok  <= 1'b0;
            r_second <= 1'b0;
            r_p      <= 4'd0;
            r_round  <= 6'd0;
            r_cnt    <= 3'd0;
            r_h      <= ssh_pkg::IV;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_dh_cfg <= i_cfg_data;
            end
            r_state  <= n_state;
            r_bits   <= n_bits;
            r_lastp  <= n_lastp;
            r_fin    <= n_fin;
            r_first  <= n_first;
            r_lenok  <= n_lenok;
            r_second <= n_second;
            r_p      <= n_p;
            r_round  <= n_round;
            r_cnt    <= n_cnt;
            r_h      <= n_h;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
        r_v   <= n_v;
        r_w   <= n_w;
    end

endmodule

>>> hdl/ssh_checker.sv
module ssh_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [31:0] o_digest_word,
    input logic [2:0]  o_word_index,
    input logic        o_last_word
);

    // No byte is taken while digest words are being delivered.
    a_stall_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall) else $error("input accepted during readout");

    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_last_word == (o_word_index == 3'd7)))
        else $error("last_word mismatch");

    a_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && !o_last_word) |=>
        (o_valid && o_word_index == $past(o_word_index) + 3'd1))
        else $error("digest words out of order");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_digest_word)))
        else $error("stalled beat changed");

endmodule

bind sha256_stream_hasher_top ssh_checker u_ssh_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_stall      (o_stall),
    .o_valid      (o_valid),
    .i_stall      (i_stall),
    .o_digest_word(o_digest_word),
    .o_word_index (o_word_index),
    .o_last_word  (o_last_word)
);

>>> test/testbench.sv
module testbench;

    typedef struct packed {
        logic [7:0] data;
        logic       is_byte;
        logic       closes;
    } t_msg_beat;

    typedef struct packed {
        ssh_pkg::t_word word;
        logic [2:0]     index;
        logic           last;
    } t_digest_beat;

    localparam ssh_pkg::t_word H_INIT [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };
    localparam int SETTLE_CYCLES = 300;
    localparam int LONG_HOLD     = 600;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic        i_cfg_data = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [7:0]  i_data_byte = '0;
    logic        i_byte_valid = 1'b0;
    logic        i_last_byte = 1'b0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [31:0] o_digest_word;
    logic [2:0]  o_word_index;
    logic        o_last_word;

    sha256_stream_hasher_top u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_data_byte   (i_data_byte),
        .i_byte_valid  (i_byte_valid),
        .i_last_byte   (i_last_byte),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_digest_word (o_digest_word),
        .o_word_index  (o_word_index),
        .o_last_word   (o_last_word)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_msg_beat    msg_q[$];
    t_digest_beat digest_q[$];

    // Hash state mirrored from the block.
    logic [7:0]     blk_buf [64];
    ssh_pkg::t_word chain [8];
    logic [5:0]     fill;
    logic [63:0]    bit_len;
    logic           double_mode = 1'b0;

    int  err_count = 0;
    int  words_checked = 0;
    int  msgs_closed = 0;
    int  msgs_doubled = 0;
    int  beats_sent = 0;
    bit  calm = 1'b0;
    int  hold_req = 0;
    int  hold_seen = 0;
    int  hold_left = 0;
    int  send_gap = 0;
    int  recv_wait = 0;

    function automatic ssh_pkg::t_word ror(ssh_pkg::t_word x, int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic void compress_block();
        ssh_pkg::t_word w [64];
        ssh_pkg::t_word v [8];
        ssh_pkg::t_word t1, t2, s0, s1;
        for (int r = 0; r < 16; r++)
            w[r] = {blk_buf[4*r], blk_buf[4*r+1], blk_buf[4*r+2], blk_buf[4*r+3]};
        for (int r = 16; r < 64; r++) begin
            s0 = ror(w[r-15], 7) ^ ror(w[r-15], 18) ^ (w[r-15] >> 3);
            s1 = ror(w[r-2], 17) ^ ror(w[r-2], 19) ^ (w[r-2] >> 10);
            w[r] = s1 + w[r-7] + s0 + w[r-16];
        end
        for (int k = 0; k < 8; k++)
            v[k] = chain[k];
        for (int r = 0; r < 64; r++) begin
            t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
                 + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ssh_pkg::ROUND_K[r] + w[r];
            t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
                 + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int k = 0; k < 8; k++)
            chain[k] = chain[k] + v[k];
    endfunction

    function automatic void restart_hash();
        for (int k = 0; k < 8; k++)
            chain[k] = H_INIT[k];
        fill = '0;
        bit_len = '0;
    endfunction

    function automatic void absorb_byte(logic [7:0] b);
        blk_buf[fill] = b;
        fill = fill + 6'd1;
        bit_len = bit_len + 64'd8;
        if (fill == 6'd0)
            compress_block();
    endfunction

    function automatic void pad_and_finish();
        int i;
        i = fill;
        blk_buf[i] = 8'h80;
        i++;
        if (i > 56) begin
            while (i < 64) begin
                blk_buf[i] = 8'h00;
                i++;
            end
            compress_block();
            i = 0;
        end
        while (i < 56) begin
            blk_buf[i] = 8'h00;
            i++;
        end
        for (int k = 0; k < 8; k++)
            blk_buf[56+k] = bit_len[63-8*k -: 8];
        compress_block();
    endfunction

    // Applies one accepted beat to the mirrored state and queues any digest.
    function automatic void hash_beat(t_msg_beat beat);
        ssh_pkg::t_word first [8];
        t_digest_beat   d;
        if (beat.is_byte)
            absorb_byte(beat.data);
        if (beat.closes) begin
            pad_and_finish();
            if (double_mode) begin
                first = chain;
                restart_hash();
                for (int k = 0; k < 32; k++)
                    absorb_byte(first[k/4][31-8*(k%4) -: 8]);
                pad_and_finish();
                msgs_doubled++;
            end
            for (int k = 0; k < 8; k++) begin
                d = '{word: chain[k], index: 3'(k), last: (k == 7)};
                digest_q.insert(digest_q.size(), d);
            end
            restart_hash();
            msgs_closed++;
        end
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch: %s got %h expected %h", what, got, want);
        err_count++;
    endtask

    // Sender.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                hash_beat('{data: i_data_byte, is_byte: i_byte_valid, closes: i_last_byte});
                beats_sent++;
            end
            if (!i_valid || !o_stall) begin
                if (send_gap > 0) begin
                    send_gap--;
                    i_valid <= 1'b0;
                end else if (msg_q.size() > 0) begin
                    t_msg_beat nxt;
                    nxt = msg_q.pop_front();
                    i_data_byte  <= nxt.data;
                    i_byte_valid <= nxt.is_byte;
                    i_last_byte  <= nxt.closes;
                    i_valid      <= 1'b1;
                    send_gap = calm ? 0 : $urandom_range(0, 4);
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off, started on request.
    always @(posedge i_clk) begin
        if (hold_seen != hold_req) begin
            hold_seen = hold_req;
            hold_left <= LONG_HOLD;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Receiver and checker.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (digest_q.size() == 0) begin
                    report_mismatch("digest beat with nothing pending", o_digest_word, '0);
                end else begin
                    t_digest_beat want;
                    want = digest_q.pop_front();
                    if (o_digest_word !== want.word)
                        report_mismatch("digest_word", o_digest_word, want.word);
                    if (o_word_index !== want.index)
                        report_mismatch("word_index", 32'(o_word_index), 32'(want.index));
                    if (o_last_word !== want.last)
                        report_mismatch("last_word", 32'(o_last_word), 32'(want.last));
                end
                words_checked++;
                recv_wait = calm ? 0 : $urandom_range(0, 4);
            end else if (recv_wait > 0) begin
                recv_wait--;
            end
            i_stall <= (hold_left > 0) || (recv_wait > 0);
        end
    end

    task automatic wait_drained();
        while (msg_q.size() > 0 || i_valid || digest_q.size() > 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_mode(logic v);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        double_mode = v;
        i_cfg_valid <= 1'b0;
    endtask

    task automatic push_beat(logic [7:0] d, logic bv, logic lb);
        t_msg_beat b;
        b = '{data: d, is_byte: bv, closes: lb};
        msg_q.insert(msg_q.size(), b);
    endtask

    // Queues one message of random bytes; returns the beats that count.
    task automatic queue_message(int len, output int counted);
        bit close_apart;
        close_apart = (len == 0) || ($urandom_range(0, 3) == 0);
        counted = 0;
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 19) == 0)
                push_beat(8'($urandom), 1'b0, 1'b0);
            push_beat(8'($urandom), 1'b1, (i == len - 1) && !close_apart);
            counted++;
        end
        if (close_apart) begin
            push_beat(8'($urandom), 1'b0, 1'b1);
            counted++;
        end
    endtask

    task automatic random_phase(int target);
        int done, got, len;
        done = 0;
        while (done < target) begin
            case ($urandom_range(0, 9))
                6:       len = $urandom_range(55, 56);
                7:       len = $urandom_range(63, 65);
                8:       len = $urandom_range(0, 130);
                9:       len = $urandom_range(1, 4);
                default: len = $urandom_range(0, 12);
            endcase
            queue_message(len, got);
            done += got;
        end
    endtask

    initial begin
        blk_buf = '{default: 8'h00};
        restart_hash();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Empty message right after reset, an idle beat, single extreme bytes.
        push_beat(8'hff, 1'b0, 1'b1);
        push_beat(8'h5a, 1'b0, 1'b0);
        push_beat(8'h00, 1'b1, 1'b1);
        push_beat(8'hff, 1'b1, 1'b1);
        push_beat("a", 1'b1, 1'b0);
        push_beat("b", 1'b1, 1'b0);
        push_beat("c", 1'b1, 1'b1);
        push_beat(8'h80, 1'b1, 1'b0);
        push_beat(8'h7f, 1'b0, 1'b1);
        wait_drained();

        write_mode(1'b1);
        push_beat(8'h00, 1'b0, 1'b1);
        push_beat("a", 1'b1, 1'b0);
        push_beat("b", 1'b1, 1'b0);
        push_beat("c", 1'b1, 1'b1);
        push_beat(8'hff, 1'b1, 1'b1);
        wait_drained();

        write_mode(1'b0);
        random_phase(100);
        wait_drained();

        // Back-to-back beats while the receiver holds off, to fill the block.
        write_mode(1'b1);
        calm = 1'b1;
        hold_req++;
        random_phase(90);
        wait_drained();
        calm = 1'b0;

        write_mode(1'b0);
        random_phase(90);
        wait_drained();

        if (digest_q.size() != 0)
            err_count++;
        $display("covered %0d input beats, %0d messages (%0d double-hashed)",
                 beats_sent, msgs_closed, msgs_doubled);
        $display("checked %0d digest words in both hash modes", words_checked);
        if (err_count == 0)
            $display("sha256_stream_hasher_top regression: pass");
        else
            $display("sha256_stream_hasher_top regression: fail");
        $finish;
    end

    initial begin
        #2000000;
        $display("sha256_stream_hasher_top regression: fail");
        $finish;
    end

endmodule

>>> sim.f
hdl/ssh_pkg.sv
hdl/ssh_ram.sv
hdl/sha256_stream_hasher_top.sv
hdl/ssh_checker.sv
test/testbench.sv
